// ===== rtl/rcmr_pkg.sv =====
// ----------------------------------------------------------------------------
// rcmr_pkg
// Types, register offsets and identification bytes of the RTC match block.
// ----------------------------------------------------------------------------
package rcmr_pkg;

  localparam int AddrW = 12;
  localparam int DataW = 32;

  // item kinds carried in the input tuser
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_WRITE = 2'd2;

  // register offsets
  localparam logic [AddrW-1:0] OFS_COUNT = 12'h000;
  localparam logic [AddrW-1:0] OFS_MATCH = 12'h004;
  localparam logic [AddrW-1:0] OFS_LOAD  = 12'h008;
  localparam logic [AddrW-1:0] OFS_CTRL  = 12'h00c;
  localparam logic [AddrW-1:0] OFS_STAT  = 12'h010;
  localparam logic [AddrW-1:0] OFS_RSTAT = 12'h014;
  localparam logic [AddrW-1:0] OFS_EOI   = 12'h018;
  localparam logic [AddrW-1:0] OFS_VER   = 12'h01c;

  // identification window 0xfe0..0xfff: top seven address bits all set
  localparam logic [6:0] ID_PAGE = 7'h7f;

  // control register bits
  localparam int CTRL_IE   = 0;
  localparam int CTRL_MASK = 1;
  localparam int CTRL_EN   = 2;

  typedef struct packed {
    logic [1:0]       mode;
    logic [AddrW-1:0] address;
    logic [DataW-1:0] write_data;
  } rcmr_item_t;

  typedef struct packed {
    logic [DataW-1:0] read_data;
    logic             irq;
    logic             access_error;
  } rcmr_result_t;

  function automatic logic [7:0] id_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h33;
      3'd1:    b = 8'h10;
      3'd2:    b = 8'h14;
      3'd3:    b = 8'h00;
      3'd4:    b = 8'h0d;
      3'd5:    b = 8'hf0;
      3'd6:    b = 8'h05;
      3'd7:    b = 8'hb1;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/rcmr_core.sv =====
// ----------------------------------------------------------------------------
// rcmr_core
// Register file, seconds counter and match interrupt; one item per strobe.
// ----------------------------------------------------------------------------
module rcmr_core import rcmr_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         exec,
  input  rcmr_item_t   item,
  output rcmr_result_t result
);

  logic [DataW-1:0] count, count_next;
  logic [DataW-1:0] match, match_next;
  logic [DataW-1:0] load, load_next;
  logic [DataW-1:0] ctrl, ctrl_next;
  logic             mstat, mstat_next;
  logic             rstat, rstat_next;

  logic [DataW-1:0] count_inc;
  logic [DataW-1:0] cmp_a, cmp_b;
  logic             check, fire;
  logic             clear;
  logic [DataW-1:0] rd;
  logic             err;

  assign count_inc = count + 1'b1;

  always_comb begin
    count_next = count;
    match_next = match;
    load_next  = load;
    ctrl_next  = ctrl;
    cmp_a      = count_inc;
    cmp_b      = match;
    check      = 1'b0;
    clear      = 1'b0;
    rd         = '0;
    err        = 1'b0;
    case (item.mode)
      MODE_TICK: begin
        count_next = count_inc;
        check      = 1'b1;
      end
      MODE_READ: begin
        if (item.address[AddrW-1:5] == ID_PAGE) begin
          rd = {24'd0, id_byte(item.address[4:2])};
        end else begin
          case (item.address)
            OFS_COUNT: rd = count;
            OFS_MATCH: rd = match;
            OFS_LOAD:  rd = load;
            OFS_CTRL:  rd = ctrl;
            OFS_STAT:  rd = {31'd0, mstat};
            OFS_RSTAT: rd = {31'd0, rstat};
            OFS_EOI:   clear = 1'b1;
            OFS_VER:   rd = '0;
            default:   err = 1'b1;
          endcase
        end
      end
      MODE_WRITE: begin
        case (item.address)
          OFS_LOAD: begin
            load_next  = item.write_data;
            count_next = item.write_data;
            cmp_a      = item.write_data;
            check      = 1'b1;
          end
          OFS_MATCH: begin
            match_next = item.write_data;
            cmp_a      = count;
            cmp_b      = item.write_data;
            check      = 1'b1;
          end
          OFS_CTRL: begin
            ctrl_next = item.write_data;
            clear     = !item.write_data[CTRL_EN];
          end
          default: err = 1'b1;
        endcase
      end
      default: ;
    endcase
  end

  assign fire = check && ctrl[CTRL_EN] && (cmp_a == cmp_b) && ctrl[CTRL_IE];

  always_comb begin
    mstat_next = mstat;
    rstat_next = rstat;
    if (fire) begin
      rstat_next = 1'b1;
      mstat_next = !ctrl[CTRL_MASK];
    end
    if (clear) begin
      rstat_next = 1'b0;
      mstat_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      match <= '0;
      load  <= '0;
      ctrl  <= '0;
      mstat <= 1'b0;
      rstat <= 1'b0;
    end else if (exec) begin
      count <= count_next;
      match <= match_next;
      load  <= load_next;
      ctrl  <= ctrl_next;
      mstat <= mstat_next;
      rstat <= rstat_next;
    end
  end

  assign result.read_data    = rd;
  assign result.irq          = mstat_next;
  assign result.access_error = err;

endmodule

// ===== rtl/rtc_counter_match_registers_top.sv =====
// From input transfer to result valid: input register, then result register
//   written as the registers update. Throughput: 1 item per cycle while the
//   result is not stalled; a stalled result holds only the stage behind it.
// Reset: rst synchronous, active high; clears counter, match, load, control
//   and both status bits, and empties both stages.
// ----------------------------------------------------------------------------
// rtc_counter_match_registers_top
// Streaming front end of the RTC block: input stage, core, result stage.
// ----------------------------------------------------------------------------
module rtc_counter_match_registers_top import rcmr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // address[11:0], write_data[43:12], zero[47:44]
  input  logic [1:0]  s_axis_tuser,  // mode[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // read_data[31:0], irq[32], zero[39:33]
  output logic        m_axis_tuser   // access_error[0]
);

  rcmr_item_t   in_item;
  logic         in_valid;
  rcmr_result_t core_result;
  rcmr_result_t out_result;
  logic         out_valid;
  logic         out_free;
  logic         exec;

  assign out_free      = !out_valid || m_axis_tready;
  assign exec          = in_valid && out_free;
  assign s_axis_tready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item.mode       <= s_axis_tuser;
      in_item.address    <= s_axis_tdata[AddrW-1:0];
      in_item.write_data <= s_axis_tdata[AddrW+DataW-1:AddrW];
    end
  end

  rcmr_core u_core (
    .clk    (clk),
    .rst    (rst),
    .exec   (exec),
    .item   (in_item),
    .result (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_valid;
    end
  end

  // hold the result until the transfer completes
  always_ff @(posedge clk) begin
    if (exec) begin
      out_result <= core_result;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'd0, out_result.irq, out_result.read_data};
  assign m_axis_tuser  = out_result.access_error;

endmodule
